// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: screen geometry defaults,
// character codes, the reset attribute and opcodes.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] ATTR_RESET   = 8'd2;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

endpackage

// ----- src/text_console_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell console with a single-port-write, registered-read screen
// memory, a cursor, and a sequencer that walks the memory to scroll or clear.
// ----------------------------------------------------------------------------
// Sequence (accept to out_valid): decode, then a character write, a read wait,
//   a sweep over all COLUMNS*ROWS cells (scroll or clear) then a flush and, on a
//   wrap, the character write, or nothing; the result then loads into out_valid.
// Throughput: one transaction at a time, next accepted in the cycle after the
//   result loads; a stalled output holds the result in the done state.
// Reset: asynchronous; clears cursor, sequencer and out_valid, sets the stored attribute to 2.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  color_attr,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  char_code,
    input  logic [10:0] read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] cursor_index,
    output logic [15:0] cell_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int LIN_W  = (CNT_W > 11) ? CNT_W : 11;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_FLUSH  = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_RDWAIT = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [7:0]        attr_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              scroll_reg, scroll_next;
    logic              pend_put_reg, pend_put_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              wr_copy_reg, wr_copy_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [1:0]        op_reg;
    logic [7:0]        ch_reg;
    logic [10:0]       ridx_reg;
    logic [15:0]       res_data_reg, res_data_next;
    logic              out_valid_reg;
    logic [10:0]       out_idx_reg;
    logic [15:0]       out_data_reg;

    logic [15:0]       mem [CELLS];
    logic [15:0]       rd_data_reg;

    logic              we_c;
    logic [ADDR_W-1:0] wa_c;
    logic [15:0]       wd_c;
    logic [ADDR_W-1:0] ra_c;
    logic [CNT_W-1:0]  lin_c;
    logic [CNT_W-1:0]  src_c;
    logic [LIN_W-1:0]  ridx_ext_c;
    logic [LIN_W-1:0]  cur_ext_c;
    logic              copy_c;
    logic              last_row_c;
    logic              in_acc_c;
    logic              out_load_c;
    logic [15:0]       blank_c;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_acc_c   = in_valid & in_ready;
    assign out_load_c = (state_reg == ST_DONE) & (~out_valid_reg | out_ready);

    assign out_valid    = out_valid_reg;
    assign cursor_index = out_idx_reg;
    assign cell_data    = out_data_reg;

    assign blank_c    = {attr_reg, CHAR_SPACE};
    assign lin_c      = base_reg + CNT_W'(col_reg);
    assign cur_ext_c  = LIN_W'(lin_c);
    assign ridx_ext_c = LIN_W'(ridx_reg);
    assign last_row_c = (row_reg == ROW_W'(ROWS - 1));
    assign copy_c     = scroll_reg & (ptr_reg < CNT_W'(CELLS - COLUMNS));
    assign src_c      = ptr_reg + CNT_W'(COLUMNS);

    // Read port: source row during a scroll, the requested cell otherwise
    always_comb
    begin
        if (state_reg == ST_SWEEP && copy_c)
        begin
            ra_c = src_c[ADDR_W-1:0];
        end
        else
        begin
            ra_c = ridx_ext_c[ADDR_W-1:0];
        end
    end

    // Write port: trailing sweep write, else the character write
    always_comb
    begin
        we_c = 1'b0;
        wa_c = lin_c[ADDR_W-1:0];
        wd_c = {attr_reg, ch_reg};
        if (wr_pend_reg)
        begin
            we_c = 1'b1;
            wa_c = wr_addr_reg;
            wd_c = wr_copy_reg ? rd_data_reg : blank_c;
        end
        else if (state_reg == ST_WRITE)
        begin
            we_c = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_c)
        begin
            mem[wa_c] <= wd_c;
        end
        rd_data_reg <= mem[ra_c];
    end

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        base_next     = base_reg;
        ptr_next      = ptr_reg;
        scroll_next   = scroll_reg;
        pend_put_next = pend_put_reg;
        res_data_next = res_data_reg;
        wr_pend_next  = 1'b0;
        wr_copy_next  = copy_c;
        wr_addr_next  = ptr_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc_c)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                res_data_next = 16'd0;
                pend_put_next = 1'b0;
                scroll_next   = 1'b0;
                ptr_next      = '0;
                state_next    = ST_DONE;
                case (op_reg)
                    OP_PUT:
                    begin
                        if (ch_reg == CHAR_NEWLINE || col_reg == COL_W'(COLUMNS))
                        begin
                            col_next      = '0;
                            pend_put_next = (ch_reg != CHAR_NEWLINE);
                            if (last_row_c)
                            begin
                                scroll_next = 1'b1;
                                state_next  = ST_SWEEP;
                            end
                            else
                            begin
                                row_next   = row_reg + ROW_W'(1);
                                base_next  = base_reg + CNT_W'(COLUMNS);
                                state_next = (ch_reg != CHAR_NEWLINE) ? ST_WRITE : ST_DONE;
                            end
                        end
                        else
                        begin
                            state_next = ST_WRITE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        base_next  = '0;
                        state_next = ST_SWEEP;
                    end
                    OP_READ:
                    begin
                        if (ridx_ext_c < LIN_W'(CELLS))
                        begin
                            state_next = ST_RDWAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SWEEP:
            begin
                // Write this cell in the next cycle, once its source data is back
                wr_pend_next = 1'b1;
                ptr_next     = ptr_reg + CNT_W'(1);
                if (ptr_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = pend_put_reg ? ST_WRITE : ST_DONE;
            end
            ST_WRITE:
            begin
                col_next   = col_reg + COL_W'(1);
                state_next = ST_DONE;
            end
            ST_RDWAIT:
            begin
                res_data_next = rd_data_reg;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load_c)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            attr_reg      <= ATTR_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            ptr_reg       <= '0;
            scroll_reg    <= 1'b0;
            pend_put_reg  <= 1'b0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            base_reg     <= base_next;
            ptr_reg      <= ptr_next;
            scroll_reg   <= scroll_next;
            pend_put_reg <= pend_put_next;
            wr_pend_reg  <= wr_pend_next;
            if (cfg_valid)
            begin
                attr_reg <= color_attr;
            end
            if (out_load_c)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_copy_reg  <= wr_copy_next;
        wr_addr_reg  <= wr_addr_next;
        res_data_reg <= res_data_next;
        if (in_acc_c)
        begin
            op_reg   <= opcode;
            ch_reg   <= char_code;
            ridx_reg <= read_index;
        end
        if (out_load_c)
        begin
            out_idx_reg  <= cur_ext_c[10:0];
            out_data_reg <= res_data_reg;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a transaction but stayed ready");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(COLUMNS))
        else $error("cursor column beyond limit");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_W'(ROWS - 1))
        else $error("cursor row beyond limit");

    a_sweep_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == ST_SWEEP || state_reg == ST_FLUSH))
        else $error("sweep write outside of sweep");

endmodule
